// ===== sv/card_number_luhn_classifier_unit_defines.svh =====
// assertion macros shared by the card number classifier rtl
// no dependencies; included by the modules that carry assertions
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_UNIT_DEFINES_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define CLC_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("clc same-cycle check failed");

// condition implies consequence in the next cycle
`define CLC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("clc next-cycle check failed");

`endif

// ===== sv/clc_pkg.sv =====
// shared types, constants and the double-dabble step for the card number classifier
// no dependencies
package clc_pkg;

   // input value and bcd image sizes
   localparam int IN_WIDTH      = 54;
   localparam int DIGIT_WIDTH   = 4;
   localparam int BCD_DIGITS    = 17;
   localparam int BCD_WIDTH     = BCD_DIGITS * DIGIT_WIDTH;
   localparam int BITS_PER_STEP = 6;
   localparam int CONV_STEPS    = IN_WIDTH / BITS_PER_STEP;
   localparam int STEP_WIDTH    = $clog2(CONV_STEPS + 1);
   localparam int CNT_WIDTH     = 5;
   localparam int MAX_DIGITS    = 16;

   // brand codes
   typedef enum logic [1:0] {
      BRAND_INVALID = 2'd0,  // no match or failed check
      BRAND_STYLE_A = 2'd1,  // 15 digits, prefix 34 or 37
      BRAND_STYLE_B = 2'd2,  // 13 or 16 digits, prefix 4
      BRAND_STYLE_C = 2'd3   // 16 digits, prefix 51 to 55
   } brand_type;

   // converter control and status
   typedef struct packed {
      logic                start;
      logic [IN_WIDTH-1:0] value;
   } conv_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } conv_stat_type;

   // one double-dabble bit: add 3 to digits of 5 or more, then shift in the bit
   function automatic logic [BCD_WIDTH-1:0] dabble_bit(
      input logic [BCD_WIDTH-1:0] bcd_val,
      input logic                 bit_val
   );
      logic [BCD_WIDTH-1:0] adj;
      adj = bcd_val;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5) begin
            adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3;
         end
      end
      return {adj[BCD_WIDTH-2:0], bit_val};
   endfunction

endpackage

// ===== sv/clc_bcd_conv.sv =====
// iterative binary to bcd converter, several input bits per cycle
// depends on clc_pkg and the classifier defines header
`include "card_number_luhn_classifier_unit_defines.svh"

module clc_bcd_conv import clc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  conv_ctrl_type        ctrl,
   output conv_stat_type        stat,
   output logic [BCD_WIDTH-1:0] bcd
);

   logic [IN_WIDTH-1:0]   bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]  bcd_ff, bcd_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [BCD_WIDTH-1:0]  bcd_step;

   // shared dabble unit: one group of input bits, msb first
   always_comb begin
      bcd_step = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         bcd_step = dabble_bit(bcd_step, bin_ff[IN_WIDTH-1-k]);
      end
   end

   // step sequencer
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         bin_in  = ctrl.value;
         bcd_in  = '0;
         step_in = STEP_WIDTH'(CONV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = bin_ff << BITS_PER_STEP;
         bcd_in  = bcd_step;
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_WIDTH'(1));
         done_in = (step_ff == STEP_WIDTH'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

   `CLC_ASSERT_SAME(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `CLC_ASSERT_SAME(a_busy_has_steps, clock, reset, busy_ff, step_ff != '0)
   `CLC_ASSERT_SAME(a_start_when_free, clock, reset, ctrl.start, !busy_ff)
   `CLC_ASSERT_NEXT(a_start_runs, clock, reset, ctrl.start, busy_ff && !done_ff)

endmodule

// ===== sv/card_number_luhn_classifier_unit.sv =====
// top level of the card number classifier: bcd split, luhn check, brand decode
// depends on clc_pkg, clc_bcd_conv and the classifier defines header
//
//  port group | dir | payload
//  req_*      | in  | card_number
//  rsp_*      | out | brand, checksum_ok, digit_count
//
// an item passes through the conversion, the hand-over of the digits, a scan of its
// decimal digits one at a time (up to 17, least significant first), a step that sees
// the scan empty and the load of the result. req_tready is high only while idle, from
// the cycle after the load. a full output register holds the block in its finish state
// until rsp_tready. reset is synchronous and active high and clears all control state.
`include "card_number_luhn_classifier_unit_defines.svh"

module card_number_luhn_classifier_unit import clc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [53:0] card_number, [55:54] zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] brand, [2] checksum_ok, [7:3] digit_count
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   conv_ctrl_type            conv_ctrl;
   conv_stat_type            conv_stat;
   logic [BCD_WIDTH-1:0]     conv_bcd;

   logic [BCD_WIDTH-1:0]     rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [DIGIT_WIDTH-1:0]   sum_ff, sum_in;
   logic [DIGIT_WIDTH-1:0]   last_ff, last_in;
   logic [DIGIT_WIDTH-1:0]   prev_ff, prev_in;

   brand_type                rsp_brand_ff, rsp_brand_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [CNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;

   logic                     req_xfer;
   logic                     out_free;
   logic                     out_load;
   logic [DIGIT_WIDTH-1:0]   digit;
   logic [DIGIT_WIDTH:0]     dbl;
   logic [DIGIT_WIDTH-1:0]   contrib;
   logic [DIGIT_WIDTH:0]     sum_wide;
   logic [DIGIT_WIDTH-1:0]   sum_next;
   logic                     check_ok;
   brand_type                brand_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_DONE) && out_free;

   // converter hookup
   assign conv_ctrl.start = req_xfer;
   assign conv_ctrl.value = req_tdata[IN_WIDTH-1:0];

   clc_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .ctrl  (conv_ctrl),
      .stat  (conv_stat),
      .bcd   (conv_bcd)
   );

   // luhn digit contribution; every second digit from the right, starting with the second, is doubled
   always_comb begin
      digit = rem_ff[DIGIT_WIDTH-1:0];
      dbl   = {digit, 1'b0};
      if (dbl > 5'd9) begin
         dbl = dbl - 5'd9;
      end
      contrib  = cnt_ff[0] ? dbl[DIGIT_WIDTH-1:0] : digit;
      sum_wide = {1'b0, sum_ff} + {1'b0, contrib};
      if (sum_wide >= 5'd10) begin
         sum_wide = sum_wide - 5'd10;
      end
      sum_next = sum_wide[DIGIT_WIDTH-1:0];
   end

   // brand decode from count and leading digits, for numbers that pass the luhn check
   always_comb begin
      check_ok   = (sum_ff == '0);
      brand_calc = BRAND_INVALID;
      if (check_ok && cnt_ff <= CNT_WIDTH'(MAX_DIGITS)) begin
         if (cnt_ff == 5'd15 && last_ff == 4'd3 && (prev_ff == 4'd4 || prev_ff == 4'd7)) begin
            brand_calc = BRAND_STYLE_A;
         end else if (cnt_ff == 5'd13 && last_ff == 4'd4) begin
            brand_calc = BRAND_STYLE_B;
         end else if (cnt_ff == 5'd16 && last_ff == 4'd5 && prev_ff >= 4'd1 &&
                      prev_ff <= 4'd5) begin
            brand_calc = BRAND_STYLE_C;
         end else if (cnt_ff == 5'd16 && last_ff == 4'd4) begin
            brand_calc = BRAND_STYLE_B;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               rem_in   = conv_bcd;
               cnt_in   = '0;
               sum_in   = '0;
               last_in  = '0;
               prev_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rem_in  = rem_ff >> DIGIT_WIDTH;
               cnt_in  = cnt_ff + 1'b1;
               sum_in  = sum_next;
               prev_in = last_ff;
               last_in = digit;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_brand_in  = rsp_brand_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (out_load) begin
         rsp_brand_in  = brand_calc;
         rsp_ok_in     = check_ok;
         rsp_count_in  = cnt_ff;
         rsp_tvalid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      rsp_brand_ff <= rsp_brand_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_ok_ff, rsp_brand_ff};

   `CLC_ASSERT_NEXT(a_xfer_starts_conv, clock, reset, req_xfer, conv_stat.busy)
   `CLC_ASSERT_SAME(a_done_in_conv, clock, reset, conv_stat.done, state_ff == ST_CONV)
   `CLC_ASSERT_SAME(a_scan_count_bound, clock, reset, state_ff == ST_SCAN,
                    cnt_ff <= CNT_WIDTH'(BCD_DIGITS))
   `CLC_ASSERT_SAME(a_fail_is_invalid, clock, reset, rsp_tvalid_ff && !rsp_ok_ff,
                    rsp_brand_ff == BRAND_INVALID)

endmodule
